[rtl/hrp_pkg.sv]
// shared types, codes and match tables of the request head parser
`timescale 1ns / 1ps

package hrp_pkg;

	// default configuration
	localparam int unsigned MAX_HEAD_DEF    = 65536;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// parser phase
	typedef enum logic [1:0] {
		PH_START,
		PH_HEAD,
		PH_DONE
	} phase_t;

	// event codes
	localparam logic [1:0] EV_START  = 2'd0;
	localparam logic [1:0] EV_HEADER = 2'd1;
	localparam logic [1:0] EV_END    = 2'd2;
	localparam logic [1:0] EV_ERROR  = 2'd3;

	// error codes
	localparam logic [2:0] ERR_BARE_CR = 3'd0;
	localparam logic [2:0] ERR_SPACE   = 3'd1;
	localparam logic [2:0] ERR_COLON   = 3'd2;
	localparam logic [2:0] ERR_LENGTH  = 3'd3;
	localparam logic [2:0] ERR_LONG    = 3'd4;

	// method, version, header and connection codes
	localparam logic [3:0] METHOD_UNKNOWN     = 4'd9;
	localparam logic [3:0] HDR_CONTENT_LENGTH = 4'd3;
	localparam logic [3:0] HDR_CONNECTION     = 4'd4;
	localparam logic [3:0] HDR_OTHER          = 4'd8;
	localparam logic [1:0] VER_1_0            = 2'd0;
	localparam logic [1:0] VER_UNKNOWN        = 2'd3;
	localparam logic [1:0] CONN_NONE          = 2'd0;
	localparam logic [1:0] CONN_KEEP          = 2'd1;
	localparam logic [1:0] CONN_CLOSE         = 2'd2;

	// special characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	// request payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_message;
	} in_t;

	// result payload
	typedef struct packed {
		logic [1:0]  event_res;
		logic [3:0]  method_or_header;
		logic [1:0]  version_code;
		logic [15:0] first_start;
		logic [15:0] first_length;
		logic [15:0] second_start;
		logic [15:0] second_length;
		logic        has_query;
		logic [31:0] content_length_value;
		logic        keep_alive;
		logic [2:0]  error_code;
		logic [15:0] header_number;
	} out_t;

	// classified byte carried through the queue
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_message;
		logic       is_space;
		logic       is_cr;
		logic       is_lf;
		logic       is_colon;
		logic       is_qmark;
		logic       is_digit;
		logic [7:0] lower;
	} item_t;

	// word tables, text right aligned
	typedef logic [167:0] word_txt_t;

	localparam word_txt_t METHOD_TXT [9] = '{
		"GET", "POST", "PUT", "HEAD", "DELETE", "CONNECT", "PATCH", "TRACE", "OPTIONS"
	};
	localparam logic [4:0] METHOD_LEN [9] = '{
		5'd3, 5'd4, 5'd3, 5'd4, 5'd6, 5'd7, 5'd5, 5'd5, 5'd7
	};
	localparam word_txt_t VERSION_TXT [3] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2.0"};
	localparam logic [4:0] VERSION_LEN [3] = '{5'd8, 5'd8, 5'd8};
	localparam word_txt_t HNAME_TXT [8] = '{
		"host", "user-agent", "content-type", "content-length", "connection",
		"upgrade", "sec-websocket-key", "sec-websocket-version"
	};
	localparam logic [4:0] HNAME_LEN [8] = '{
		5'd4, 5'd10, 5'd12, 5'd14, 5'd10, 5'd7, 5'd17, 5'd21
	};
	localparam word_txt_t CONN_TXT [2] = '{"keep-alive", "close"};
	localparam logic [4:0] CONN_LEN [2] = '{5'd10, 5'd5};

	// character i of a word equals c
	function automatic logic word_hit(word_txt_t s, logic [4:0] n, logic [4:0] i,
			logic [7:0] c);
		logic [4:0] pos;
		logic [7:0] ch;
		pos = (i < n) ? 5'(n - 5'd1 - i) : 5'd0;
		ch  = s[{pos, 3'b000} +: 8];
		return (i < n) && (ch == c);
	endfunction

	function automatic logic [8:0] method_step(logic [8:0] m, logic [4:0] i, logic [7:0] c);
		logic [8:0] r;
		r = m;
		for (int k = 0; k < 9; k++) begin
			if (!word_hit(METHOD_TXT[k], METHOD_LEN[k], i, c)) r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [2:0] version_step(logic [2:0] m, logic [4:0] i, logic [7:0] c);
		logic [2:0] r;
		r = m;
		for (int k = 0; k < 3; k++) begin
			if (!word_hit(VERSION_TXT[k], VERSION_LEN[k], i, c)) r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [7:0] name_step(logic [7:0] m, logic [4:0] i, logic [7:0] c);
		logic [7:0] r;
		r = m;
		for (int k = 0; k < 8; k++) begin
			if (!word_hit(HNAME_TXT[k], HNAME_LEN[k], i, c)) r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [1:0] conn_step(logic [1:0] m, logic [4:0] i, logic [7:0] c);
		logic [1:0] r;
		r = m;
		for (int k = 0; k < 2; k++) begin
			if (!word_hit(CONN_TXT[k], CONN_LEN[k], i, c)) r[k] = 1'b0;
		end
		return r;
	endfunction

	// lowest surviving candidate whose length matches
	function automatic logic [3:0] method_pick(logic [8:0] m, logic [4:0] i);
		logic [3:0] r;
		r = METHOD_UNKNOWN;
		for (int k = 8; k >= 0; k--) begin
			if (m[k] && METHOD_LEN[k] == i) r = 4'(k);
		end
		return r;
	endfunction

	function automatic logic [1:0] version_pick(logic [2:0] m, logic [4:0] i);
		logic [1:0] r;
		r = VER_UNKNOWN;
		for (int k = 2; k >= 0; k--) begin
			if (m[k] && VERSION_LEN[k] == i) r = 2'(k);
		end
		return r;
	endfunction

	function automatic logic [3:0] name_pick(logic [7:0] m, logic [4:0] i);
		logic [3:0] r;
		r = HDR_OTHER;
		for (int k = 7; k >= 0; k--) begin
			if (m[k] && HNAME_LEN[k] == i) r = 4'(k);
		end
		return r;
	endfunction

	function automatic logic [1:0] conn_pick(logic [1:0] m, logic [4:0] i);
		logic [1:0] r;
		r = 2'd2;
		for (int k = 1; k >= 0; k--) begin
			if (m[k] && CONN_LEN[k] == i) r = 2'(k);
		end
		return r;
	endfunction

	// byte classification
	function automatic item_t classify(logic [7:0] c, logic som);
		item_t r;
		r.data_byte        = c;
		r.start_of_message = som;
		r.is_space         = (c == CH_SPACE);
		r.is_cr            = (c == CH_CR);
		r.is_lf            = (c == CH_LF);
		r.is_colon         = (c == CH_COLON);
		r.is_qmark         = (c == CH_QMARK);
		r.is_digit         = (c >= 8'h30) && (c <= 8'h39);
		r.lower            = ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
		return r;
	endfunction

endpackage

[rtl/http_request_head_parser.sv]
// top level of the request head parser
// Usage:
//   head channel: one byte of the request head per request, with
//   start_of_message marking the first byte of a new request (it clears
//   all parser state). head_valid / head_stall handshake.
//   result channel: start line, header line, end of head or error events,
//   at most one per byte, result_valid / result_stall handshake.
// Path: a taken byte is first written into the queue, then the parser
//   stage reads it from the queue and writes its result register.
// Throughput: one byte per cycle without stalls. A CR inside a header
//   line that is not followed by LF costs the parser a step of its own,
//   since it is folded into the header state before the byte after it.
// After an end of head or an error, bytes are taken and dropped until
//   start_of_message is seen. Heads longer than MAX_HEAD_BYTES bytes fail.
// Reset: asynchronous, clears the queue pointers, the parser state and the
//   result valid flag; no clearing pass is needed.
// Stall: a valid result holds while stalled, the parser waits and
//   the byte queue (QUEUE_DEPTH entries) keeps taking bytes until full.
`timescale 1ns / 1ps

module http_request_head_parser #(
	parameter int unsigned MAX_HEAD_BYTES = hrp_pkg::MAX_HEAD_DEF,
	parameter int unsigned QUEUE_DEPTH    = hrp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	output logic          head_stall,
	input  hrp_pkg::in_t  head,
	output logic          result_valid,
	input  logic          result_stall,
	output hrp_pkg::out_t result
);
	import hrp_pkg::*;

	logic  push;
	item_t push_item;
	logic  queue_full;
	logic  pop;
	logic  pop_valid;
	item_t pop_item;

	// classify incoming bytes
	hrp_front u_front (
		.head_valid (head_valid),
		.head       (head),
		.head_stall (head_stall),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	// decoupling queue
	hrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	// parser and result register
	hrp_back #(
		.MAX_HEAD_BYTES (MAX_HEAD_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (pop_valid),
		.item         (pop_item),
		.item_pop     (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[rtl/hrp_front.sv]
// front end: takes request bytes and classifies them into the queue
`timescale 1ns / 1ps

module hrp_front (
	input  logic          head_valid,
	input  hrp_pkg::in_t  head,
	output logic          head_stall,
	output logic          push,
	output hrp_pkg::item_t push_item,
	input  logic          queue_full
);
	import hrp_pkg::*;

	// accept whenever the queue has room
	assign head_stall = queue_full;
	assign push       = head_valid && !queue_full;

	// character classes and lower case form
	assign push_item = classify(head.data_byte, head.start_of_message);

endmodule

[rtl/hrp_queue.sv]
// short queue of classified bytes between front and back
`timescale 1ns / 1ps

module hrp_queue #(
	parameter int unsigned DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hrp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output hrp_pkg::item_t pop_item
);
	import hrp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (!push && do_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/hrp_back.sv]
// back end: parser state update and result register
`timescale 1ns / 1ps

module hrp_back #(
	parameter int unsigned MAX_HEAD_BYTES = hrp_pkg::MAX_HEAD_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  hrp_pkg::item_t item,
	output logic           item_pop,
	output logic           result_valid,
	input  logic           result_stall,
	output hrp_pkg::out_t  result
);
	import hrp_pkg::*;

	localparam int unsigned OFS_W = $clog2(MAX_HEAD_BYTES + 1);
	typedef logic [OFS_W-1:0] ofs_t;
	localparam ofs_t OFS_MAX = OFS_W'(MAX_HEAD_BYTES);

	typedef struct packed {
		phase_t      phase;
		ofs_t        byte_offset;
		logic [1:0]  space_count;
		logic        cr_pending;
		ofs_t        token_start;
		logic [4:0]  match_index;
		logic [8:0]  method_cand;
		logic [2:0]  version_cand;
		logic [3:0]  method_seen;
		logic [1:0]  version_seen;
		ofs_t        query_pos;
		logic        query_found;
		ofs_t        line_start;
		logic        colon_found;
		logic [15:0] name_length;
		ofs_t        value_start;
		logic        skipping;
		logic [7:0]  name_cand;
		logic [31:0] digit_acc;
		logic        digits_invalid;
		logic [1:0]  conn_cand;
		logic [1:0]  conn_seen;
		logic [15:0] header_count;
		ofs_t        uri_start;
		ofs_t        uri_end;
		logic [4:0]  value_index;
	} st_t;

	localparam st_t ST_RESET = '{
		phase: PH_START, byte_offset: '0, space_count: '0, cr_pending: 1'b0,
		token_start: '0, match_index: '0, method_cand: '1, version_cand: '1,
		method_seen: METHOD_UNKNOWN, version_seen: VER_UNKNOWN, query_pos: '0,
		query_found: 1'b0, line_start: '0, colon_found: 1'b0, name_length: '0,
		value_start: '0, skipping: 1'b0, name_cand: '1, digit_acc: '0,
		digits_invalid: 1'b0, conn_cand: '1, conn_seen: CONN_NONE,
		header_count: '0, uri_start: '0, uri_end: '0, value_index: '0
	};

	st_t         st_q;
	st_t         st;
	logic        out_valid_q;
	out_t        out_q;
	out_t        res;
	logic        res_v;
	logic        advance;
	logic        cr_cycle;
	logic        do_hdr;
	item_t       hc;
	ofs_t        off;
	ofs_t        cr_off;
	ofs_t        diff;
	ofs_t        vlen;
	logic [3:0]  id;
	logic [35:0] acc_ext;

	function automatic logic [15:0] lo16(ofs_t x);
		logic [31:0] w;
		w = 32'(x);
		return w[15:0];
	endfunction

	function automatic logic [4:0] sat5(logic [4:0] v);
		return (v == 5'd31) ? v : v + 5'd1;
	endfunction

	function automatic out_t fail_res(logic [2:0] code, logic [15:0] hcnt);
		out_t r;
		r               = '0;
		r.event_res     = EV_ERROR;
		r.error_code    = code;
		r.header_number = hcnt;
		return r;
	endfunction

	function automatic st_t new_line(st_t s, ofs_t start);
		st_t r;
		r                = s;
		r.line_start     = start;
		r.colon_found    = 1'b0;
		r.name_length    = '0;
		r.value_start    = '0;
		r.skipping       = 1'b0;
		r.name_cand      = '1;
		r.match_index    = '0;
		r.digit_acc      = '0;
		r.digits_invalid = 1'b0;
		r.conn_cand      = '1;
		r.value_index    = '0;
		return r;
	endfunction

	function automatic st_t finish_token(st_t s, ofs_t stop);
		st_t r;
		r = s;
		if (s.space_count == 2'd0) begin
			r.method_seen = method_pick(s.method_cand, s.match_index);
		end else if (s.space_count == 2'd1) begin
			r.uri_start = s.token_start;
			r.uri_end   = stop;
		end else begin
			r.version_seen = version_pick(s.version_cand, s.match_index);
		end
		return r;
	endfunction

	// a deferred bare cr inside a header line is a parser step of its own
	assign advance  = item_valid && (!out_valid_q || !result_stall);
	assign cr_cycle = st_q.cr_pending && (st_q.phase == PH_HEAD) &&
		!item.start_of_message && !item.is_lf && (st_q.byte_offset < OFS_MAX);

	// parser step
	always_comb begin
		st       = st_q;
		res      = '0;
		res_v    = 1'b0;
		item_pop = 1'b0;
		do_hdr   = 1'b0;
		hc       = item;
		off      = st_q.byte_offset;
		cr_off   = '0;
		diff     = '0;
		vlen     = '0;
		id       = HDR_OTHER;
		acc_ext  = '0;
		if (advance) begin
			if (cr_cycle) begin
				st.cr_pending = 1'b0;
				hc            = classify(CH_CR, 1'b0);
				do_hdr        = 1'b1;
			end else begin
				item_pop = 1'b1;
				if (item.start_of_message) st = ST_RESET;
				if (st.phase != PH_DONE) begin
					if (st.byte_offset >= OFS_MAX) begin
						res_v    = 1'b1;
						res      = fail_res(ERR_LONG, st.header_count);
						st.phase = PH_DONE;
					end else begin
						off            = st.byte_offset;
						st.byte_offset = off + 1'b1;
						cr_off         = off - 1'b1;
						if (st.cr_pending) begin
							st.cr_pending = 1'b0;
							if (!item.is_lf) begin
								// bare cr on the start line
								res_v    = 1'b1;
								res      = fail_res(ERR_BARE_CR, st.header_count);
								st.phase = PH_DONE;
							end else if (st.phase == PH_START) begin
								// start line done
								st                   = finish_token(st, cr_off);
								res_v                = 1'b1;
								res.event_res        = EV_START;
								res.method_or_header = st.method_seen;
								res.version_code     = st.version_seen;
								res.header_number    = st.header_count;
								if (st.space_count != 2'd0) begin
									res.first_start = lo16(st.uri_start);
									if (st.query_found) begin
										diff              = st.query_pos - st.uri_start;
										res.first_length  = lo16(diff);
										diff              = st.query_pos + 1'b1;
										res.second_start  = lo16(diff);
										diff              = st.uri_end - st.query_pos - 1'b1;
										res.second_length = lo16(diff);
										res.has_query     = 1'b1;
									end else begin
										diff             = st.uri_end - st.uri_start;
										res.first_length = lo16(diff);
									end
								end
								st.phase = PH_HEAD;
								st       = new_line(st, off + 1'b1);
							end else if (cr_off == st.line_start) begin
								// empty line ends the head
								res_v                = 1'b1;
								res.event_res        = EV_END;
								res.method_or_header = st.method_seen;
								res.version_code     = st.version_seen;
								res.keep_alive       = (st.version_seen == VER_1_0) ?
									(st.conn_seen == CONN_KEEP) : (st.conn_seen != CONN_CLOSE);
								res.header_number    = st.header_count;
								st.phase             = PH_DONE;
							end else if (!st.colon_found) begin
								res_v    = 1'b1;
								res      = fail_res(ERR_COLON, st.header_count);
								st.phase = PH_DONE;
							end else begin
								// header line done
								id   = name_pick(st.name_cand, st.match_index);
								vlen = cr_off - st.value_start;
								if (id == HDR_CONTENT_LENGTH &&
										(st.digits_invalid || vlen == '0)) begin
									res_v    = 1'b1;
									res      = fail_res(ERR_LENGTH, st.header_count);
									st.phase = PH_DONE;
								end else begin
									if (id == HDR_CONNECTION) begin
										st.conn_seen =
											conn_pick(st.conn_cand, st.value_index) + 2'd1;
									end
									if (st.header_count != 16'hFFFF) begin
										st.header_count = st.header_count + 16'd1;
									end
									res_v                = 1'b1;
									res.event_res        = EV_HEADER;
									res.method_or_header = id;
									res.version_code     = st.version_seen;
									res.first_start      = lo16(st.line_start);
									res.first_length     = st.name_length;
									res.second_start     = lo16(st.value_start);
									res.second_length    = lo16(vlen);
									res.content_length_value =
										(id == HDR_CONTENT_LENGTH) ? st.digit_acc : 32'd0;
									res.header_number    = st.header_count;
									st = new_line(st, off + 1'b1);
								end
							end
						end else if (item.is_cr) begin
							st.cr_pending = 1'b1;
						end else if (st.phase == PH_START) begin
							// start line byte
							if (item.is_space) begin
								if (st.space_count == 2'd2 || st.space_count == 2'd3) begin
									res_v    = 1'b1;
									res      = fail_res(ERR_SPACE, st.header_count);
									st.phase = PH_DONE;
								end else begin
									st             = finish_token(st, off);
									st.space_count = st.space_count + 2'd1;
									st.token_start = off + 1'b1;
									st.match_index = '0;
								end
							end else begin
								if (st.space_count == 2'd0) begin
									st.method_cand = method_step(st.method_cand,
										st.match_index, item.data_byte);
								end else if (st.space_count == 2'd2) begin
									st.version_cand = version_step(st.version_cand,
										st.match_index, item.data_byte);
								end else if (item.is_qmark && !st.query_found) begin
									st.query_found = 1'b1;
									st.query_pos   = off;
								end
								st.match_index = sat5(st.match_index);
							end
						end else begin
							do_hdr = 1'b1;
						end
					end
				end
			end
		end

		// header line byte
		if (do_hdr) begin
			if (!st.colon_found) begin
				if (hc.is_colon) begin
					st.colon_found = 1'b1;
					diff           = off - st.line_start;
					st.name_length = lo16(diff);
					st.value_start = off + 1'b1;
					st.skipping    = 1'b1;
				end else begin
					st.name_cand   = name_step(st.name_cand, st.match_index, hc.lower);
					st.match_index = sat5(st.match_index);
				end
			end else if (st.skipping && hc.is_space) begin
				st.value_start = off + 1'b1;
			end else begin
				st.skipping = 1'b0;
				if (hc.is_digit) begin
					acc_ext = ({4'b0, st.digit_acc} << 3) + ({4'b0, st.digit_acc} << 1) +
						{32'b0, hc.data_byte[3:0]};
					if (acc_ext[35:32] != 4'b0) st.digits_invalid = 1'b1;
					else st.digit_acc = acc_ext[31:0];
				end else begin
					st.digits_invalid = 1'b1;
				end
				st.conn_cand   = conn_step(st.conn_cand, st.value_index, hc.lower);
				st.value_index = sat5(st.value_index);
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else begin
			st_q <= st;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !result_stall) begin
			out_valid_q <= advance && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_v) out_q <= res;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

[sim/http_request_head_parser_test.sv]
// testbench of the request head parser: random heads checked against a byte-level predictor
`timescale 1ns / 1ps

// predicted results in order, compared as a whole
class head_scoreboard;
	hrp_pkg::out_t pending[$];
	int errors;

	function void note(hrp_pkg::out_t r);
		pending.push_back(r);
	endfunction

	function void check(hrp_pkg::out_t got);
		hrp_pkg::out_t want;
		if (pending.size() == 0) begin
			$display("%0t unexpected result: expected none, actual %h", $realtime, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			$display("%0t result mismatch: expected %h, actual %h", $realtime, want, got);
			errors++;
		end
	endfunction
endclass

module http_request_head_parser_test;
	import hrp_pkg::*;

	localparam int unsigned MAX_BYTES = 65536;
	localparam int          CYCLE_LIMIT = 200000;

	logic  clk;
	logic  arst_n;
	logic  head_valid;
	logic  head_stall;
	in_t   head;
	logic  result_valid;
	logic  result_stall;
	out_t  result;

	head_scoreboard board;
	int    cycles;
	bit    calm;
	bit    hold_off;
	bit    sending;

	// parser state of the predictor
	phase_t      p_phase;
	int unsigned p_off, p_spaces, p_tok, p_idx, p_qpos, p_line, p_nlen, p_vstart;
	int unsigned p_acc, p_hdrs, p_uri_s, p_uri_e, p_vidx;
	bit          p_cr, p_qfound, p_colon, p_skip, p_bad;
	logic [8:0]  p_meth_m;
	logic [2:0]  p_ver_m;
	logic [7:0]  p_name_m;
	logic [1:0]  p_conn_m;
	logic [3:0]  p_meth;
	logic [1:0]  p_ver;
	logic [1:0]  p_conn;

	string meth_words[9] = '{"GET", "POST", "PUT", "HEAD", "DELETE", "CONNECT", "PATCH",
		"TRACE", "OPTIONS"};
	string ver_words[3] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2.0"};
	string name_words[8] = '{"host", "user-agent", "content-type", "content-length",
		"connection", "upgrade", "sec-websocket-key", "sec-websocket-version"};
	string conn_words[2] = '{"keep-alive", "close"};

	http_request_head_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_stall   (head_stall),
		.head         (head),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// narrow a candidate mask by one character against a word list
	function automatic int unsigned mask_step(int unsigned m, string w[], int unsigned i,
			logic [7:0] c);
		int unsigned r;
		r = m;
		foreach (w[k]) begin
			if (!(i < w[k].len() && w[k][i] == c)) r &= ~(1 << k);
		end
		return r;
	endfunction

	// lowest surviving word of exactly the length seen
	function automatic int unsigned mask_pick(int unsigned m, string w[], int unsigned i,
			int unsigned none);
		foreach (w[k]) begin
			if (m[k] && w[k].len() == i) return k;
		end
		return none;
	endfunction

	function automatic void new_line(int unsigned s);
		p_line = s; p_colon = 0; p_nlen = 0; p_vstart = 0; p_skip = 0;
		p_name_m = '1; p_idx = 0; p_acc = 0; p_bad = 0; p_conn_m = '1; p_vidx = 0;
	endfunction

	function automatic void clear_all();
		p_phase = PH_START; p_off = 0; p_spaces = 0; p_cr = 0; p_tok = 0; p_idx = 0;
		p_meth_m = '1; p_ver_m = '1; p_meth = METHOD_UNKNOWN; p_ver = VER_UNKNOWN;
		p_qpos = 0; p_qfound = 0; p_conn = CONN_NONE; p_hdrs = 0; p_uri_s = 0; p_uri_e = 0;
		new_line(0);
	endfunction

	function automatic out_t failure(logic [2:0] code);
		out_t r;
		r = '0;
		r.event_res = EV_ERROR;
		r.error_code = code;
		r.header_number = 16'(p_hdrs);
		p_phase = PH_DONE;
		return r;
	endfunction

	function automatic void end_token(int unsigned e);
		if (p_spaces == 0) p_meth = 4'(mask_pick(p_meth_m, meth_words, p_idx, METHOD_UNKNOWN));
		else if (p_spaces == 1) begin
			p_uri_s = p_tok; p_uri_e = e;
		end else p_ver = 2'(mask_pick(p_ver_m, ver_words, p_idx, VER_UNKNOWN));
	endfunction

	function automatic void header_byte(logic [7:0] c, int unsigned o);
		longint unsigned v;
		if (!p_colon) begin
			if (c == CH_COLON) begin
				p_colon = 1; p_nlen = o - p_line; p_vstart = o + 1; p_skip = 1;
			end else begin
				p_name_m = 8'(mask_step(p_name_m, name_words, p_idx, to_lower(c)));
				if (p_idx < 31) p_idx++;
			end
			return;
		end
		if (p_skip && c == CH_SPACE) begin
			p_vstart = o + 1;
			return;
		end
		p_skip = 0;
		if (c >= "0" && c <= "9") begin
			v = longint'(p_acc) * 10 + (c - "0");
			if (v > 64'hFFFF_FFFF) p_bad = 1;
			else p_acc = 32'(v);
		end else p_bad = 1;
		p_conn_m = 2'(mask_step(p_conn_m, conn_words, p_vidx, to_lower(c)));
		if (p_vidx < 31) p_vidx++;
	endfunction

	// line ended by CR LF at offset o of the LF
	function automatic bit line_done(int unsigned o, output out_t r);
		int unsigned cr_o, id, vlen;
		cr_o = o - 1;
		r = '0;
		r.version_code = p_ver;
		if (p_phase == PH_START) begin
			end_token(cr_o);
			r.version_code = p_ver;
			r.event_res = EV_START;
			r.method_or_header = p_meth;
			r.header_number = 16'(p_hdrs);
			if (p_spaces >= 1) begin
				r.first_start = 16'(p_uri_s);
				if (p_qfound) begin
					r.first_length = 16'(p_qpos - p_uri_s);
					r.second_start = 16'(p_qpos + 1);
					r.second_length = 16'(p_uri_e - p_qpos - 1);
					r.has_query = 1;
				end else r.first_length = 16'(p_uri_e - p_uri_s);
			end
			p_phase = PH_HEAD;
			new_line(o + 1);
			return 1;
		end
		if (cr_o == p_line) begin
			r.event_res = EV_END;
			r.method_or_header = p_meth;
			r.keep_alive = (p_ver == VER_1_0) ? (p_conn == CONN_KEEP) : (p_conn != CONN_CLOSE);
			r.header_number = 16'(p_hdrs);
			p_phase = PH_DONE;
			return 1;
		end
		if (!p_colon) begin
			r = failure(ERR_COLON);
			return 1;
		end
		id = mask_pick(p_name_m, name_words, p_idx, HDR_OTHER);
		vlen = cr_o - p_vstart;
		if (id == HDR_CONTENT_LENGTH && (p_bad || vlen == 0)) begin
			r = failure(ERR_LENGTH);
			return 1;
		end
		if (id == HDR_CONNECTION) p_conn = 2'(mask_pick(p_conn_m, conn_words, p_vidx, 2) + 1);
		if (p_hdrs < 65535) p_hdrs++;
		r.event_res = EV_HEADER;
		r.method_or_header = 4'(id);
		r.first_start = 16'(p_line);
		r.first_length = 16'(p_nlen);
		r.second_start = 16'(p_vstart);
		r.second_length = 16'(vlen);
		r.content_length_value = (id == HDR_CONTENT_LENGTH) ? p_acc : 0;
		r.header_number = 16'(p_hdrs);
		new_line(o + 1);
		return 1;
	endfunction

	// predict the result, if any, of one request byte
	function automatic bit predict_byte(in_t b, output out_t r);
		int unsigned o;
		logic [7:0] c;
		c = b.data_byte;
		r = '0;
		if (b.start_of_message) clear_all();
		if (p_phase == PH_DONE) return 0;
		if (p_off >= MAX_BYTES) begin
			r = failure(ERR_LONG);
			return 1;
		end
		o = p_off;
		p_off++;
		if (p_cr) begin
			p_cr = 0;
			if (c == CH_LF) return line_done(o, r);
			if (p_phase == PH_START) begin
				r = failure(ERR_BARE_CR);
				return 1;
			end
			header_byte(CH_CR, o - 1);
		end
		if (c == CH_CR) begin
			p_cr = 1;
			return 0;
		end
		if (p_phase == PH_START) begin
			if (c == CH_SPACE) begin
				if (p_spaces >= 2) begin
					r = failure(ERR_SPACE);
					return 1;
				end
				end_token(o);
				p_spaces++;
				p_tok = o + 1;
				p_idx = 0;
				return 0;
			end
			if (p_spaces == 0) p_meth_m = 9'(mask_step(p_meth_m, meth_words, p_idx, c));
			else if (p_spaces == 2) p_ver_m = 3'(mask_step(p_ver_m, ver_words, p_idx, c));
			else if (c == CH_QMARK && !p_qfound) begin
				p_qfound = 1; p_qpos = o;
			end
			if (p_idx < 31) p_idx++;
			return 0;
		end
		header_byte(c, o);
		return 0;
	endfunction

	// offer one request byte and wait for it to be taken
	task automatic send_byte(logic [7:0] c, bit som);
		out_t r;
		if (!calm && $urandom_range(0, 5) == 0) begin
			head_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		head_valid <= 1'b1;
		head <= '{data_byte: c, start_of_message: som};
		@(posedge clk);
		while (head_stall) @(posedge clk);
		if (predict_byte('{data_byte: c, start_of_message: som}, r)) board.note(r);
		@(negedge clk);
	endtask

	task automatic send_text(string s, bit som);
		foreach (s[i]) send_byte(s[i], som && i == 0);
	endtask

	function automatic string pick_word(string w[]);
		return w[$urandom_range(0, w.size() - 1)];
	endfunction

	// random token of printable characters, no space, cr or colon
	function automatic string noise_token(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h41, 8'h7A)))};
		return s;
	endfunction

	function automatic string mixed_case(string s);
		foreach (s[i]) begin
			if ($urandom_range(0, 1) && s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 8'd32;
		end
		return s;
	endfunction

	// one well formed head with random content and occasional breakage
	task automatic send_head();
		string s, tgt, val, nm;
		int n;
		s = ($urandom_range(0, 7) == 0) ? noise_token($urandom_range(1, 8))
			: pick_word(meth_words);
		tgt = {"/", noise_token($urandom_range(0, 6))};
		if ($urandom_range(0, 1)) tgt = {tgt, "?", noise_token($urandom_range(0, 5))};
		s = {s, " ", tgt};
		if ($urandom_range(0, 9) != 0) s = {s, " ", ($urandom_range(0, 7) == 0)
			? noise_token(8) : pick_word(ver_words)};
		if ($urandom_range(0, 24) == 0) s = {s, " x"};
		s = {s, "\r\n"};
		n = $urandom_range(0, 5);
		for (int h = 0; h < n; h++) begin
			nm = ($urandom_range(0, 4) == 0) ? noise_token($urandom_range(1, 6))
				: mixed_case(pick_word(name_words));
			if (nm.tolower() == "content-length") begin
				case ($urandom_range(0, 5))
					0: val = "";
					1: val = "12a";
					2: val = "4294967296";
					3: val = "4294967295";
					default: val = $sformatf("%0d", $urandom_range(0, 99999));
				endcase
			end else if (nm.tolower() == "connection") begin
				val = $urandom_range(0, 2) ? mixed_case(pick_word(conn_words)) : "upgrade";
			end else val = noise_token($urandom_range(0, 6));
			if ($urandom_range(0, 19) == 0) s = {s, nm, " no colon\r\n"};
			else s = {s, nm, ":", ($urandom_range(0, 1) ? "  " : ""), val, "\r\n"};
		end
		if ($urandom_range(0, 19) == 0) s = {s, "a:\rb\r\n"};
		s = {s, "\r\n"};
		if ($urandom_range(0, 3) == 0) s = {s, "tail"};
		send_text(s, 1);
	endtask

	// random byte noise
	task automatic send_noise(int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
	endtask

	// receiver: random stall bursts, none in the calm part; a long stall on hold-off
	initial begin
		result_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				result_stall <= 1'b1;
				repeat (60) @(negedge clk);
				hold_off = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			result_stall <= 1'b0;
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) board.check(result);
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		board = new();
		cycles = 0;
		calm = 0;
		hold_off = 0;
		arst_n = 1'b0;
		head_valid = 1'b0;
		head = '0;
		clear_all();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed heads
		send_text("GET /a?b HTTP/1.1\r\nHost: x\r\nContent-Length: 4294967295\r\n\r\n", 1);
		send_text("OPTIONS * HTTP/1.0\r\nConnection: keep-alive\r\n\r\n", 1);
		send_text("A B C D", 1);
		send_text("GET /\rx", 1);
		send_text("GET\r\nnocolon\r\n", 1);
		send_text("PUT / HTTP/2.0\r\nContent-Length: 1x\r\n", 1);
		send_byte(8'hFF, 1);
		send_byte(8'h00, 0);

		// long stall on the result side while bytes keep coming
		hold_off = 1;
		send_text("POST /q? HTTP/1.1\r\nA:1\r\nB:2\r\nC:3\r\nD:4\r\nE:5\r\nF:6\r\n\r\n", 1);

		// random part
		for (int i = 0; i < 7; i++) begin
			if ($urandom_range(0, 5) == 0) send_noise($urandom_range(1, 20));
			else send_head();
			if (i == 4) calm = 1;
		end
		head_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/hrp_pkg.sv
rtl/hrp_front.sv
rtl/hrp_queue.sv
rtl/hrp_back.sv
rtl/http_request_head_parser.sv
sim/http_request_head_parser_test.sv
